[rtl/core/srm_pkg.sv]
// Package for the sliding window rank median: field types, defaults, controller states.
package srm_pkg;

    // Default geometry and lane count
    localparam int WINDOW_WIDTH_DEF  = 3;
    localparam int WINDOW_HEIGHT_DEF = 3;
    localparam int LANES_DEF         = 4;

    // Fixed field widths and the number of lane fields carried in a request
    localparam int MAX_LANES = 4;
    localparam int SAMPLE_W  = 8;
    localparam int PTR_IN_W  = 4;

    // Input request
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic                step_back;
        logic                pointer_load;
        logic [PTR_IN_W-1:0] pointer_value;
    } src_t;

    // Result request
    typedef struct packed {
        logic [SAMPLE_W-1:0] median_0;
        logic [SAMPLE_W-1:0] median_1;
        logic [SAMPLE_W-1:0] median_2;
        logic [SAMPLE_W-1:0] median_3;
    } res_t;

    // Strobes from the controller to every lane
    typedef struct packed {
        logic load;
        logic update;
    } lane_ctrl_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PICK
    } ctrl_state_t;

endpackage

[rtl/core/sliding_window_rank_median.sv]
// Sliding window rank median: up to four lanes of running median over a ring window.
//
// Source channel src_valid/src_stall/src_data carries one request: a new 8-bit
// sample per lane plus the ring pointer controls (load, value, step direction).
// Result channel res_valid/res_stall/res_data returns one request per input:
// the middle-ranked value of each lane's window after the new sample is in.
// Lanes at or above LANES report zero.
// The result is registered: the accepting edge loads each lane's new sample, the
// rank update step re-ranks the window, and the pick step loads the output register
// once it is free. The controller takes one request at a time through these steps,
// and every cell of a lane updates on the same update strobe. src_stall is high
// whenever the controller is not idle. When the receiver stalls, the result stays in
// the output register; the next request advances to the pick step and waits there,
// so no request beyond it is taken. Reset: window values zero, cell k holds rank k,
// ring pointer zero, no result pending.
module sliding_window_rank_median #(
    parameter int WINDOW_WIDTH  = srm_pkg::WINDOW_WIDTH_DEF,
    parameter int WINDOW_HEIGHT = srm_pkg::WINDOW_HEIGHT_DEF,
    parameter int LANES         = srm_pkg::LANES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    output logic          src_stall,
    input  srm_pkg::src_t src_data,
    output logic          res_valid,
    input  logic          res_stall,
    output srm_pkg::res_t res_data
);

    localparam int WIN_N  = WINDOW_WIDTH * WINDOW_HEIGHT;
    localparam int CLOG_N = $clog2(WIN_N);
    localparam int RANK_W = (CLOG_N > 0) ? CLOG_N : 1;
    localparam int PTR_W  = RANK_W;

    srm_pkg::lane_ctrl_t          lane_ctrl;
    logic [PTR_W-1:0]             slot;
    logic                         res_load;
    logic                         res_free;
    logic                         res_valid_reg;
    srm_pkg::res_t                res_data_reg;
    logic [srm_pkg::SAMPLE_W-1:0] lane_sample [srm_pkg::MAX_LANES];
    logic [srm_pkg::SAMPLE_W-1:0] lane_median [srm_pkg::MAX_LANES];

    assign res_free = !res_valid_reg || !res_stall;

    srm_ctrl #(
        .WIN_N (WIN_N),
        .PTR_W (PTR_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .step_back     (src_data.step_back),
        .pointer_load  (src_data.pointer_load),
        .pointer_value (src_data.pointer_value),
        .res_free      (res_free),
        .lane_ctrl     (lane_ctrl),
        .slot          (slot),
        .res_load      (res_load)
    );

    // Split the request into per-lane samples
    assign lane_sample[0] = src_data.sample_0;
    assign lane_sample[1] = src_data.sample_1;
    assign lane_sample[2] = src_data.sample_2;
    assign lane_sample[3] = src_data.sample_3;

    // Build the active lanes; tie off the rest
    for (genvar l = 0; l < srm_pkg::MAX_LANES; l++)
    begin : g_lane
        if (l < LANES)
        begin : g_on
            srm_lane #(
                .WIN_N  (WIN_N),
                .RANK_W (RANK_W),
                .PTR_W  (PTR_W)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .lane_ctrl (lane_ctrl),
                .slot      (slot),
                .sample    (lane_sample[l]),
                .median    (lane_median[l])
            );
        end
        else
        begin : g_off
            assign lane_median[l] = '0;
        end
    end

    // Merge lane medians into the output register; drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg.median_0 <= lane_median[0];
            res_data_reg.median_1 <= lane_median[1];
            res_data_reg.median_2 <= lane_median[2];
            res_data_reg.median_3 <= lane_median[3];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // An accepted request is ranked in the very next cycle
    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> lane_ctrl.update)
        else $error("accepted request not followed by rank update");

    // No request is taken while a rank update is under way
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctrl.update |-> src_stall)
        else $error("request accepted during rank update");

    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid || !res_stall))
        else $error("stalled result overwritten");

    // Ring pointer stays inside the window
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot <= PTR_W'(WIN_N - 1))
        else $error("ring pointer out of range");

endmodule

[rtl/core/srm_lane.sv]
// One lane: window cells with values and ranks, rank update and median pick.
module srm_lane #(
    parameter int WIN_N  = 9,
    parameter int RANK_W = 4,
    parameter int PTR_W  = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srm_pkg::lane_ctrl_t           lane_ctrl,
    input  logic [PTR_W-1:0]              slot,
    input  logic [srm_pkg::SAMPLE_W-1:0]  sample,
    output logic [srm_pkg::SAMPLE_W-1:0]  median
);

    localparam int MED_RANK = (WIN_N - 1) / 2;

    logic [srm_pkg::SAMPLE_W-1:0] value_reg [WIN_N];
    logic [RANK_W-1:0]            rank_reg  [WIN_N];
    logic [srm_pkg::SAMPLE_W-1:0] value_next [WIN_N];
    logic [RANK_W-1:0]            rank_next  [WIN_N];
    logic [srm_pkg::SAMPLE_W-1:0] fresh_reg;
    logic [srm_pkg::SAMPLE_W-1:0] old_val;
    logic [RANK_W-1:0]            old_rank;
    logic [RANK_W-1:0]            new_rank;

    // Hold the new sample until the update cycle
    always_ff @(posedge clk)
    begin
        if (lane_ctrl.load)
        begin
            fresh_reg <= sample;
        end
    end

    // Fetch the value and rank that leave the window
    always_comb
    begin
        old_val  = '0;
        old_rank = '0;
        for (int k = 0; k < WIN_N; k++)
        begin
            if (PTR_W'(k) == slot)
            begin
                old_val  = value_reg[k];
                old_rank = rank_reg[k];
            end
        end
    end

    // Re-rank every remaining cell and count those below the new sample
    always_comb
    begin
        logic dec;
        logic inc;
        new_rank = '0;
        for (int k = 0; k < WIN_N; k++)
        begin
            dec = (value_reg[k] > old_val) ||
                  ((value_reg[k] == old_val) && (rank_reg[k] > old_rank));
            inc = (value_reg[k] >= fresh_reg);
            value_next[k] = value_reg[k];
            rank_next[k]  = rank_reg[k] - RANK_W'(dec) + RANK_W'(inc);
            if ((PTR_W'(k) != slot) && !inc)
            begin
                new_rank = new_rank + RANK_W'(1);
            end
        end
        for (int k = 0; k < WIN_N; k++)
        begin
            if (PTR_W'(k) == slot)
            begin
                value_next[k] = fresh_reg;
                rank_next[k]  = new_rank;
            end
        end
    end

    // Advance the window on the update strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_N; k++)
            begin
                value_reg[k] <= '0;
                rank_reg[k]  <= RANK_W'(k);
            end
        end
        else if (lane_ctrl.update)
        begin
            for (int k = 0; k < WIN_N; k++)
            begin
                value_reg[k] <= value_next[k];
                rank_reg[k]  <= rank_next[k];
            end
        end
    end

    // Pick the value holding the middle rank; ranks are a permutation
    always_comb
    begin
        median = '0;
        for (int k = 0; k < WIN_N; k++)
        begin
            if (rank_reg[k] == RANK_W'(MED_RANK))
            begin
                median = median | value_reg[k];
            end
        end
    end

endmodule

[rtl/core/srm_ctrl.sv]
// Controller: ring pointer and the accept, update, pick sequence.
module srm_ctrl #(
    parameter int WIN_N = 9,
    parameter int PTR_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  logic                          step_back,
    input  logic                          pointer_load,
    input  logic [srm_pkg::PTR_IN_W-1:0]  pointer_value,
    input  logic                          res_free,
    output srm_pkg::lane_ctrl_t           lane_ctrl,
    output logic [PTR_W-1:0]              slot,
    output logic                          res_load
);

    localparam int CMP_W = (PTR_W > srm_pkg::PTR_IN_W) ? PTR_W : srm_pkg::PTR_IN_W;

    srm_pkg::ctrl_state_t state_reg;
    srm_pkg::ctrl_state_t state_next;
    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     ptr_next;
    logic [PTR_W-1:0]     ptr_base;
    logic [CMP_W-1:0]     pv_ext;
    logic                 accept;

    assign accept = src_valid && !src_stall;

    // Load with saturation, then step with wrap
    always_comb
    begin
        pv_ext = CMP_W'(pointer_value);
        if (!pointer_load)
        begin
            ptr_base = ptr_reg;
        end
        else if (pv_ext >= CMP_W'(WIN_N - 1))
        begin
            ptr_base = PTR_W'(WIN_N - 1);
        end
        else
        begin
            ptr_base = pv_ext[PTR_W-1:0];
        end
        if (step_back)
        begin
            ptr_next = (ptr_base == '0) ? PTR_W'(WIN_N - 1) : ptr_base - PTR_W'(1);
        end
        else
        begin
            ptr_next = (ptr_base >= PTR_W'(WIN_N - 1)) ? '0 : ptr_base + PTR_W'(1);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srm_pkg::ST_IDLE:
            begin
                if (src_valid)
                begin
                    state_next = srm_pkg::ST_UPDATE;
                end
            end
            srm_pkg::ST_UPDATE:
            begin
                state_next = srm_pkg::ST_PICK;
            end
            srm_pkg::ST_PICK:
            begin
                if (res_free)
                begin
                    state_next = srm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        src_stall        = 1'b1;
        lane_ctrl.load   = 1'b0;
        lane_ctrl.update = 1'b0;
        res_load         = 1'b0;
        case (state_reg)
            srm_pkg::ST_IDLE:
            begin
                src_stall      = 1'b0;
                lane_ctrl.load = src_valid;
            end
            srm_pkg::ST_UPDATE:
            begin
                lane_ctrl.update = 1'b1;
            end
            srm_pkg::ST_PICK:
            begin
                res_load = res_free;
            end
            default:
            begin
                src_stall = 1'b1;
            end
        endcase
    end

    // Hold state and pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srm_pkg::ST_IDLE;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                ptr_reg <= ptr_next;
            end
        end
    end

    assign slot = ptr_reg;

endmodule

[dv/sliding_window_rank_median_tb.sv]
// Testbench for the sliding window rank median: rank-tracking predictor, scoreboard and drivers.
module sliding_window_rank_median_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_N      = srm_pkg::WINDOW_WIDTH_DEF * srm_pkg::WINDOW_HEIGHT_DEF;
    localparam int MID_RANK   = (WIN_N - 1) / 2;
    localparam int QUIET_MAX  = 2000;
    localparam int REPORT_MAX = 10;
    localparam int PHASE_REQS = 283;
    localparam int HOLD_LEN   = 200;

    logic          clk;
    logic          rst_n;
    logic          src_valid;
    logic          src_stall;
    srm_pkg::src_t src_data;
    logic          res_valid;
    logic          res_stall;
    srm_pkg::res_t res_data;

    // Idling controls for the drivers, one per side; hold_request counts hold-offs asked for
    int src_idle_pct;
    int res_stall_pct;
    int hold_request;

    // Running median predictor and queue of expected medians
    class median_board;
        logic [7:0]    lane_vals [srm_pkg::MAX_LANES][WIN_N];
        logic [7:0]    lane_ranks [srm_pkg::MAX_LANES][WIN_N];
        int            ring_ptr;
        srm_pkg::res_t expected_q[$];
        int            mismatches;

        function new();
            for (int l = 0; l < srm_pkg::MAX_LANES; l++)
            begin
                for (int k = 0; k < WIN_N; k++)
                begin
                    lane_vals[l][k]  = '0;
                    lane_ranks[l][k] = 8'(k);
                end
            end
            ring_ptr   = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Replace one slot of a lane, re-rank the rest, return the middle value
        function logic [7:0] rank_update(int lane, logic [7:0] fresh, int slot);
            logic [7:0] old_val;
            logic [7:0] old_rank;
            logic [7:0] new_rank;
            logic [7:0] med;
            logic [7:0] v;
            logic [7:0] r;
            int         k;
            old_val  = lane_vals[lane][slot];
            old_rank = lane_ranks[lane][slot];
            new_rank = '0;
            med      = '0;
            for (k = 0; k < WIN_N; k++)
            begin
                if (k != slot)
                begin
                    v = lane_vals[lane][k];
                    r = lane_ranks[lane][k];
                    // close the gap left by the outgoing value
                    if (v > old_val || (v == old_val && r > old_rank))
                        r = r - 8'd1;
                    // open a gap below values not less than the incoming one
                    if (v >= fresh)
                        r = r + 8'd1;
                    else
                        new_rank = new_rank + 8'd1;
                    lane_ranks[lane][k] = r;
                    if (r == MID_RANK)
                        med = med + v;
                end
            end
            lane_vals[lane][slot]  = fresh;
            lane_ranks[lane][slot] = new_rank;
            if (new_rank == MID_RANK)
                med = med + fresh;
            return med;
        endfunction

        // Advance the ring pointer and queue the medians for one request
        function void note_request(srm_pkg::src_t req);
            logic [7:0]    samples [srm_pkg::MAX_LANES];
            logic [7:0]    meds [srm_pkg::MAX_LANES];
            srm_pkg::res_t res;
            int            p;
            p = ring_ptr;
            if (req.pointer_load)
                p = (req.pointer_value >= WIN_N) ? WIN_N - 1 : int'(req.pointer_value);
            if (req.step_back)
                p = (p == 0) ? WIN_N - 1 : p - 1;
            else
                p = (p >= WIN_N - 1) ? 0 : p + 1;
            ring_ptr = p;
            samples = '{req.sample_0, req.sample_1, req.sample_2, req.sample_3};
            for (int l = 0; l < srm_pkg::MAX_LANES; l++)
            begin
                if (l < srm_pkg::LANES_DEF)
                    meds[l] = rank_update(l, samples[l], p);
                else
                    meds[l] = '0;
            end
            res.median_0 = meds[0];
            res.median_1 = meds[1];
            res.median_2 = meds[2];
            res.median_3 = meds[3];
            expected_q.push_back(res);
        endfunction

        // Compare a delivered result with the oldest expectation, lane by lane
        function void check_result(srm_pkg::res_t got);
            srm_pkg::res_t want;
            logic [7:0]    want_f [srm_pkg::MAX_LANES];
            logic [7:0]    got_f [srm_pkg::MAX_LANES];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result %h with no request outstanding", $realtime, got);
                return;
            end
            want   = expected_q.pop_front();
            want_f = '{want.median_0, want.median_1, want.median_2, want.median_3};
            got_f  = '{got.median_0, got.median_1, got.median_2, got.median_3};
            for (int l = 0; l < srm_pkg::MAX_LANES; l++)
            begin
                if (got_f[l] !== want_f[l])
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: median_%0d expected %0d, got %0d",
                                 $realtime, l, want_f[l], got_f[l]);
                end
            end
        endfunction
    endclass

    median_board board;

    sliding_window_rank_median DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watch both channels; note requests and check results as they are taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
                board.note_request(src_data);
            if (res_valid && !res_stall)
                board.check_result(res_data);
        end
    end

    // Result side: random stalls, or a long hold-off counted here when one is asked for
    initial
    begin
        int holds_seen;
        int hold_left;
        holds_seen = 0;
        hold_left  = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != holds_seen)
            begin
                holds_seen = hold_request;
                hold_left  = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= ($urandom_range(99) < res_stall_pct);
        end
    end

    // Abort when no request moves on either channel for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((src_valid && !src_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic srm_pkg::src_t make_request(logic [7:0] s0, logic [7:0] s1,
                                                   logic [7:0] s2, logic [7:0] s3,
                                                   logic back, logic load,
                                                   logic [3:0] ptr);
        srm_pkg::src_t req;
        req.sample_0      = s0;
        req.sample_1      = s1;
        req.sample_2      = s2;
        req.sample_3      = s3;
        req.step_back     = back;
        req.pointer_load  = load;
        req.pointer_value = ptr;
        return req;
    endfunction

    // Mix of full-range, tie-prone and extreme samples
    function automatic logic [7:0] pick_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return 8'($urandom_range(255));
        if (sel < 8)
            return 8'(120 + $urandom_range(3));
        return (sel == 8) ? 8'hFF : 8'h00;
    endfunction

    function automatic srm_pkg::src_t random_request();
        return make_request(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                            ($urandom_range(99) < 30), ($urandom_range(99) < 10),
                            4'($urandom_range(15)));
    endfunction

    // Offer one request, with random idle gaps ahead of it, and hold it until taken
    task automatic send_request(input srm_pkg::src_t req);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= req;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        src_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board         = new();
        src_idle_pct  = 0;
        res_stall_pct = 0;
        hold_request  = 0;
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        src_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, pointer wrap and saturation, ties
        send_request(make_request(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 4'd0));
        send_request(make_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 4'd0));
        send_request(make_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 4'd0));
        send_request(make_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 4'd0));
        send_request(make_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 4'd0));
        send_request(make_request(8'h00, 8'hFF, 8'h80, 8'h01, 1'b1, 1'b0, 4'd0));
        send_request(make_request(8'h07, 8'h07, 8'h07, 8'h07, 1'b1, 1'b1, 4'd0));
        send_request(make_request(8'hFF, 8'h00, 8'h07, 8'hC8, 1'b0, 1'b1, 4'd8));
        send_request(make_request(8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 1'b1, 4'd9));
        send_request(make_request(8'h80, 8'h80, 8'h80, 8'h80, 1'b1, 1'b1, 4'd15));
        send_request(make_request(8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 1'b1, 4'd4));
        send_request(make_request(8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 4'd0));
        send_request(make_request(8'h7F, 8'h81, 8'h80, 8'h80, 1'b0, 1'b0, 4'd0));
        send_request(make_request(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1, 1'b1, 4'd10));
        send_request(make_request(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b0, 4'd5));
        send_request(make_request(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 4'd0));
        send_request(make_request(8'h01, 8'hFE, 8'h00, 8'hFF, 1'b0, 1'b1, 4'd0));
        send_request(make_request(8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 1'b1, 4'd7));
        send_request(make_request(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 4'd0));
        drain_results();

        // Random phases with different idling on each side
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 0;
                    res_stall_pct = 0;
                    // hold the result side so the block backs up its input
                    hold_request  = hold_request + 1;
                end
                1:
                begin
                    src_idle_pct  = 73;
                    res_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    res_stall_pct = 73;
                end
                default:
                begin
                    src_idle_pct  = 37;
                    res_stall_pct = 37;
                end
            endcase
            repeat (PHASE_REQS) send_request(random_request());
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/srm_pkg.sv
rtl/core/srm_lane.sv
rtl/core/srm_ctrl.sv
rtl/core/sliding_window_rank_median.sv
dv/sliding_window_rank_median_tb.sv
